// ----- rtl/hcbd_pkg.sv -----
`timescale 1ns / 1ps

package hcbd_pkg;

    // Configuration register width and reset value
    localparam int CFG_W = 32;
    localparam logic [CFG_W-1:0] MAX_BODY_RESET = 32'h0010_0000;

    // Default width of the chunk size counters
    localparam int SIZE_BITS_DEF = 32;

    // Running body total is kept wide so that it never wraps before the limit check
    localparam int TOTAL_W = 64;

    // Protocol characters
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_ZERO = 8'h30;

    typedef enum logic [2:0] {
        PH_SIZE_FIRST = 3'd0,
        PH_SIZE_MORE  = 3'd1,
        PH_SIZE_LF    = 3'd2,
        PH_DATA       = 3'd3,
        PH_DATA_CR    = 3'd4,
        PH_DATA_LF    = 3'd5,
        PH_DONE       = 3'd6,
        PH_FAILED     = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_DONE = 2'd1,
        ST_FAIL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_BAD_DIGIT  = 3'd1,
        ERR_NO_LF      = 3'd2,
        ERR_LEAD_ZERO  = 3'd3,
        ERR_TOO_LARGE  = 3'd4,
        ERR_BAD_END    = 3'd5,
        ERR_AFTER_END  = 3'd6
    } t_err;

    // One decoded result
    typedef struct packed {
        logic [7:0] body_byte;
        logic       body_valid;
        t_status    status;
        t_err       error_kind;
    } t_result;

    // Return {invalid, value}; invalid is set for a byte that is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = {1'b0, 4'(c[3:0] + 4'd9)};
        end
        return v;
    endfunction

endpackage

// ----- rtl/hcbd_if.sv -----
`timescale 1ns / 1ps

// Raw byte channel into the decoder
interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic       new_message;
    logic [7:0] data_byte;

    modport source (output valid, output new_message, output data_byte, input ready);
    modport sink   (input valid, input new_message, input data_byte, output ready);
endinterface

// Decoded result channel out of the decoder
interface hcbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;
    logic       body_valid;
    logic [1:0] status;
    logic [2:0] error_kind;

    modport source (output valid, output body_byte, output body_valid, output status,
                    output error_kind, input ready);
    modport sink   (input valid, input body_byte, input body_valid, input status,
                    input error_kind, output ready);
endinterface

// ----- rtl/hcbd_core.sv -----
`timescale 1ns / 1ps

module hcbd_core
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_new_message,
    input  logic [7:0]       i_data_byte,
    input  logic [CFG_W-1:0] i_max_body_bytes,
    output t_result          o_result
);

    t_phase               r_phase, n_phase;
    logic [SIZE_BITS-1:0] r_size, n_size;
    logic                 r_multi, n_multi;
    logic                 r_first_zero, n_first_zero;
    logic [SIZE_BITS-1:0] r_left, n_left;
    logic [TOTAL_W-1:0]   r_total, n_total;

    t_phase               cur_phase;
    logic [SIZE_BITS-1:0] cur_size;
    logic                 cur_multi;
    logic                 cur_first_zero;
    logic [SIZE_BITS-1:0] cur_left;
    logic [TOTAL_W-1:0]   cur_total;

    logic [4:0]           hex;
    logic [TOTAL_W-1:0]   size_wide;
    logic [TOTAL_W-1:0]   room;
    logic [SIZE_BITS-1:0] left_dec;
    t_err                 err;
    t_status              st;
    logic                 valid;

    // Hold decoder state; advance on each request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SIZE_FIRST;
            r_size       <= '0;
            r_multi      <= 1'b0;
            r_first_zero <= 1'b0;
            r_left       <= '0;
            r_total      <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_size       <= n_size;
            r_multi      <= n_multi;
            r_first_zero <= n_first_zero;
            r_left       <= n_left;
            r_total      <= n_total;
        end
    end

    // Clear state at the start of a message
    always_comb begin
        cur_phase      = i_new_message ? PH_SIZE_FIRST : r_phase;
        cur_size       = i_new_message ? '0 : r_size;
        cur_multi      = i_new_message ? 1'b0 : r_multi;
        cur_first_zero = i_new_message ? 1'b0 : r_first_zero;
        cur_left       = i_new_message ? '0 : r_left;
        cur_total      = i_new_message ? '0 : r_total;
    end

    assign hex       = hex_value(i_data_byte);
    assign size_wide = TOTAL_W'(cur_size);
    assign room      = TOTAL_W'(i_max_body_bytes) - cur_total;
    assign left_dec  = cur_left - SIZE_BITS'(1);

    // Decode one byte against the current phase
    always_comb begin
        n_phase      = cur_phase;
        n_size       = cur_size;
        n_multi      = cur_multi;
        n_first_zero = cur_first_zero;
        n_left       = cur_left;
        n_total      = cur_total;
        err          = ERR_NONE;
        st           = ST_BUSY;
        valid        = 1'b0;

        unique case (cur_phase)
            PH_SIZE_FIRST: begin
                if (hex[4]) begin
                    err = ERR_BAD_DIGIT;
                end else begin
                    n_size       = SIZE_BITS'(hex[3:0]);
                    n_first_zero = (i_data_byte == CH_ZERO);
                    n_multi      = 1'b0;
                    n_phase      = PH_SIZE_MORE;
                end
            end
            PH_SIZE_MORE: begin
                if (i_data_byte == CH_CR) begin
                    n_phase = PH_SIZE_LF;
                end else if (hex[4]) begin
                    err = ERR_BAD_DIGIT;
                end else begin
                    n_multi = 1'b1;
                    if (|cur_size[SIZE_BITS-1 -: 4]) begin
                        err = ERR_TOO_LARGE;
                    end else begin
                        n_size = {cur_size[SIZE_BITS-5:0], hex[3:0]};
                    end
                end
            end
            PH_SIZE_LF: begin
                if (i_data_byte != CH_LF) begin
                    err = ERR_NO_LF;
                end else if (cur_first_zero) begin
                    if (cur_multi) begin
                        err = ERR_LEAD_ZERO;
                    end else begin
                        n_phase = PH_DONE;
                        st      = ST_DONE;
                    end
                end else if (size_wide > room) begin
                    err = ERR_TOO_LARGE;
                end else begin
                    n_total = cur_total + size_wide;
                    n_left  = cur_size;
                    n_size  = '0;
                    n_phase = (cur_size != '0) ? PH_DATA : PH_DATA_CR;
                end
            end
            PH_DATA: begin
                valid  = 1'b1;
                n_left = left_dec;
                if (left_dec == '0) begin
                    n_phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                if (i_data_byte != CH_CR) begin
                    err = ERR_BAD_END;
                end else begin
                    n_phase = PH_DATA_LF;
                end
            end
            PH_DATA_LF: begin
                if (i_data_byte != CH_LF) begin
                    err = ERR_BAD_END;
                end else begin
                    n_phase = PH_SIZE_FIRST;
                end
            end
            PH_DONE, PH_FAILED: begin
                err = ERR_AFTER_END;
            end
            default: begin
                err = ERR_AFTER_END;
            end
        endcase

        // Any error drops the byte and parks the decoder
        if (err != ERR_NONE) begin
            n_phase = PH_FAILED;
            st      = ST_FAIL;
            valid   = 1'b0;
        end

        o_result.body_byte  = valid ? i_data_byte : 8'h00;
        o_result.body_valid = valid;
        o_result.status     = st;
        o_result.error_kind = err;
    end

endmodule

// ----- rtl/http_chunked_body_decoder_unit.sv -----
`timescale 1ns / 1ps

// Chunked HTTP body decoder: one raw byte in, one result out per request.
// Input channel i_in carries new_message and data_byte; set new_message on
// the first byte of a message to clear the parse state. Output channel o_out
// returns one result per input byte: body_byte/body_valid for payload bytes,
// status (in progress, finished, failed) and error_kind.
// The size limit is written through i_cfg_we/i_cfg_wdata; write it only
// while no bytes are in flight.
// From input acceptance to the earliest output handshake, a byte passes
// through the input register and then the output register. Throughput is
// one byte per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more byte before ready drops.
// Reset clears the parse state to the start of a size line, empties both
// registers and loads the size limit with 1 MiB.
module http_chunked_body_decoder_unit
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hcbd_in_if.sink          i_in,
    hcbd_out_if.source       o_out,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    logic [CFG_W-1:0] r_max;
    logic             r_in_valid;
    logic             r_in_new;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    t_result          r_out;
    t_result          result;
    logic             advance;

    // Hold the size limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_BODY_RESET;
        end else if (i_cfg_we) begin
            r_max <= i_cfg_wdata;
        end
    end

    // Move a request from the input register into the output register
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // Capture the incoming request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_new  <= i_in.new_message;
            r_in_byte <= i_in.data_byte;
        end
    end

    hcbd_core #(
        .SIZE_BITS(SIZE_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (advance),
        .i_new_message   (r_in_new),
        .i_data_byte     (r_in_byte),
        .i_max_body_bytes(r_max),
        .o_result        (result)
    );

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.body_byte  = r_out.body_byte;
    assign o_out.body_valid = r_out.body_valid;
    assign o_out.status     = r_out.status;
    assign o_out.error_kind = r_out.error_kind;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top
    import hcbd_pkg::*;
;

    localparam int SIZE_W       = SIZE_BITS_DEF;
    localparam int RUN_ITEMS    = 1430;
    localparam int QUIET_TAIL   = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 600;
    localparam int LIMIT_EVERY  = 220;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PRINT_CAP    = 100;

    // One raw byte request: new_message flag and the stream byte
    typedef struct packed {
        logic       nm;
        logic [7:0] b;
    } t_raw_byte;

    typedef enum logic {
        ROW_BYTE,
        ROW_LIMIT
    } t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [CFG_W-1:0] limit;
        logic             nm;
        logic [7:0]       b;
        logic             typed;
        t_result          want;
    } t_dir_row;

    localparam t_result UNCHECKED  = '0;
    localparam t_result GOT_DONE   = '{8'h00, 1'b0, ST_DONE, ERR_NONE};
    localparam t_result DATA_00    = '{8'h00, 1'b1, ST_BUSY, ERR_NONE};
    localparam t_result DATA_FF    = '{8'hff, 1'b1, ST_BUSY, ERR_NONE};
    localparam t_result FAIL_DIGIT = '{8'h00, 1'b0, ST_FAIL, ERR_BAD_DIGIT};
    localparam t_result FAIL_NO_LF = '{8'h00, 1'b0, ST_FAIL, ERR_NO_LF};
    localparam t_result FAIL_LEAD0 = '{8'h00, 1'b0, ST_FAIL, ERR_LEAD_ZERO};
    localparam t_result FAIL_BIG   = '{8'h00, 1'b0, ST_FAIL, ERR_TOO_LARGE};
    localparam t_result FAIL_END   = '{8'h00, 1'b0, ST_FAIL, ERR_BAD_END};
    localparam t_result FAIL_AFTER = '{8'h00, 1'b0, ST_FAIL, ERR_AFTER_END};

    // Directed stream: lone zero end, byte after end, bad first digit, missing LF,
    // leading zero, data extremes, bad data terminator, size over a zero limit
    localparam int DIR_ROWS = 26;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{ROW_BYTE,  32'd0,          1'b1, CH_ZERO, 1'b0, UNCHECKED},
        '{ROW_BYTE,  32'd0,          1'b0, CH_CR,   1'b0, UNCHECKED},
        '{ROW_BYTE,  32'd0,          1'b0, CH_LF,   1'b1, GOT_DONE},
        '{ROW_BYTE,  32'd0,          1'b0, 8'h00,   1'b1, FAIL_AFTER},
        '{ROW_BYTE,  32'd0,          1'b1, 8'hff,   1'b1, FAIL_DIGIT},
        '{ROW_BYTE,  32'd0,          1'b1, "a",     1'b0, UNCHECKED},
        '{ROW_BYTE,  32'd0,          1'b0, "F",     1'b0, UNCHECKED},
        '{ROW_BYTE,  32'd0,          1'b0, CH_CR,   1'b0, UNCHECKED},
        '{ROW_BYTE,  32'd0,          1'b0, 8'h00,   1'b1, FAIL_NO_LF},
        '{ROW_BYTE,  32'd0,          1'b1, CH_ZERO, 1'b0, UNCHECKED},
        '{ROW_BYTE,  32'd0,          1'b0, CH_ZERO, 1'b0, UNCHECKED},
        '{ROW_BYTE,  32'd0,          1'b0, CH_CR,   1'b0, UNCHECKED},
        '{ROW_BYTE,  32'd0,          1'b0, CH_LF,   1'b1, FAIL_LEAD0},
        '{ROW_BYTE,  32'd0,          1'b1, "2",     1'b0, UNCHECKED},
        '{ROW_BYTE,  32'd0,          1'b0, CH_CR,   1'b0, UNCHECKED},
        '{ROW_BYTE,  32'd0,          1'b0, CH_LF,   1'b0, UNCHECKED},
        '{ROW_BYTE,  32'd0,          1'b0, 8'h00,   1'b1, DATA_00},
        '{ROW_BYTE,  32'd0,          1'b0, 8'hff,   1'b1, DATA_FF},
        '{ROW_BYTE,  32'd0,          1'b0, CH_CR,   1'b0, UNCHECKED},
        '{ROW_BYTE,  32'd0,          1'b0, "z",     1'b1, FAIL_END},
        '{ROW_LIMIT, 32'd0,          1'b0, 8'h00,   1'b0, UNCHECKED},
        '{ROW_BYTE,  32'd0,          1'b1, "1",     1'b0, UNCHECKED},
        '{ROW_BYTE,  32'd0,          1'b0, CH_CR,   1'b0, UNCHECKED},
        '{ROW_BYTE,  32'd0,          1'b0, CH_LF,   1'b1, FAIL_BIG},
        '{ROW_LIMIT, 32'hffff_ffff,  1'b0, 8'h00,   1'b0, UNCHECKED},
        '{ROW_BYTE,  32'd0,          1'b1, "g",     1'b1, FAIL_DIGIT}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    hcbd_in_if  in_ch ();
    hcbd_out_if out_ch ();

    http_chunked_body_decoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Decoder state mirrored by the predictor
    t_phase           ph;
    logic [SIZE_W-1:0] size_acc;
    logic             multi_digit;
    logic             lead_zero;
    logic [SIZE_W-1:0] remaining;
    logic [63:0]      total_so_far;
    logic [CFG_W-1:0] body_limit;

    t_result   pending_results[$];
    t_raw_byte msg_q[$];
    int        mismatch_count = 0;
    int        items_accepted = 0;
    int        cycle_count = 0;
    bit        idle_on = 1'b1;
    bit        hold_req = 1'b0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // End the run if it stalls
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_CAP) begin
            $display("ERROR cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
        end
        mismatch_count++;
    endtask

    function automatic void clear_parse();
        ph           = PH_SIZE_FIRST;
        size_acc     = '0;
        multi_digit  = 1'b0;
        lead_zero    = 1'b0;
        remaining    = '0;
        total_so_far = '0;
    endfunction

    // Hex digit value, bit 4 set for anything else
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
        if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
        return 5'h10;
    endfunction

    // Advance the mirrored decoder by one byte and return its result
    function automatic t_result decode_byte(input logic nm, input logic [7:0] c);
        t_result    r;
        t_err       fault;
        logic [4:0] d;
        r     = '{8'h00, 1'b0, ST_BUSY, ERR_NONE};
        fault = ERR_NONE;
        if (nm) clear_parse();
        d = digit_value(c);
        case (ph)
            PH_SIZE_FIRST: begin
                if (d[4]) begin
                    fault = ERR_BAD_DIGIT;
                end else begin
                    size_acc    = SIZE_W'(d[3:0]);
                    lead_zero   = (c == CH_ZERO);
                    multi_digit = 1'b0;
                    ph          = PH_SIZE_MORE;
                end
            end
            PH_SIZE_MORE: begin
                if (c == CH_CR) begin
                    ph = PH_SIZE_LF;
                end else if (d[4]) begin
                    fault = ERR_BAD_DIGIT;
                end else begin
                    multi_digit = 1'b1;
                    // Fail as soon as another digit would shift bits out
                    if (size_acc[SIZE_W-1 -: 4] != 4'h0) fault = ERR_TOO_LARGE;
                    else size_acc = {size_acc[SIZE_W-5:0], d[3:0]};
                end
            end
            PH_SIZE_LF: begin
                if (c != CH_LF) begin
                    fault = ERR_NO_LF;
                end else if (lead_zero) begin
                    if (multi_digit) begin
                        fault = ERR_LEAD_ZERO;
                    end else begin
                        ph       = PH_DONE;
                        r.status = ST_DONE;
                    end
                end else if (64'(size_acc) > 64'(body_limit) - total_so_far) begin
                    fault = ERR_TOO_LARGE;
                end else begin
                    total_so_far = total_so_far + 64'(size_acc);
                    remaining    = size_acc;
                    size_acc     = '0;
                    ph           = (remaining != '0) ? PH_DATA : PH_DATA_CR;
                end
            end
            PH_DATA: begin
                r.body_valid = 1'b1;
                r.body_byte  = c;
                remaining    = remaining - SIZE_W'(1);
                if (remaining == '0) ph = PH_DATA_CR;
            end
            PH_DATA_CR: begin
                if (c != CH_CR) fault = ERR_BAD_END;
                else ph = PH_DATA_LF;
            end
            PH_DATA_LF: begin
                if (c != CH_LF) fault = ERR_BAD_END;
                else ph = PH_SIZE_FIRST;
            end
            default: begin
                fault = ERR_AFTER_END;
            end
        endcase
        if (fault != ERR_NONE) begin
            ph = PH_FAILED;
            r  = '{8'h00, 1'b0, ST_FAIL, fault};
        end
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input int unsigned v);
        if (v < 10) return 8'(CH_ZERO + v);
        return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
    endfunction

    function automatic void put_byte(input logic nm, input logic [7:0] b);
        msg_q.insert(msg_q.size(), t_raw_byte'{nm, b});
    endfunction

    // Emit a size line in minimal hex with optional leading zeros, then CR LF
    function automatic void put_size_line(input logic [31:0] sz, input int unsigned pad);
        int unsigned ndig;
        ndig = 1;
        while (ndig < 8 && (sz >> (4 * ndig)) != 0) ndig++;
        repeat (pad) put_byte(1'b0, CH_ZERO);
        for (int i = int'(ndig) - 1; i >= 0; i--) begin
            put_byte(1'b0, hex_char((sz >> (4 * i)) & 32'hf));
        end
        put_byte(1'b0, CH_CR);
        put_byte(1'b0, CH_LF);
    endfunction

    // Build one chunked message; some get a broken size line, a damaged byte
    // or a byte after the end
    function automatic void build_message();
        int unsigned first;
        int unsigned chunks;
        int unsigned sz;
        int unsigned fault_mode;
        int unsigned at;
        first      = msg_q.size();
        fault_mode = $urandom_range(0, 11);
        chunks     = (fault_mode >= 9) ? $urandom_range(1, 4) : $urandom_range(0, 4);
        for (int k = 0; k < int'(chunks); k++) begin
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 120) : $urandom_range(1, 12);
            if (k == 0 && fault_mode == 9) begin
                put_size_line(sz, $urandom_range(1, 2));
            end else if (k == 0 && fault_mode == 10) begin
                // Too many digits for the size counter
                put_byte(1'b0, hex_char($urandom_range(1, 15)));
                repeat ($urandom_range(8, 11)) put_byte(1'b0, hex_char($urandom_range(0, 15)));
                put_byte(1'b0, CH_CR);
                put_byte(1'b0, CH_LF);
            end else if (k == 0 && fault_mode == 11) begin
                put_size_line($urandom_range(32'h1000, 32'hff_ffff), 0);
            end else begin
                put_size_line(sz, 0);
            end
            repeat (sz) put_byte(1'b0, 8'($urandom_range(0, 255)));
            put_byte(1'b0, CH_CR);
            put_byte(1'b0, CH_LF);
        end
        put_byte(1'b0, CH_ZERO);
        put_byte(1'b0, CH_CR);
        put_byte(1'b0, CH_LF);
        if (fault_mode == 7) put_byte(1'b0, 8'($urandom_range(0, 255)));
        if (fault_mode == 8) begin
            at = $urandom_range(first, msg_q.size() - 1);
            case ($urandom_range(0, 2))
                0: msg_q[at].b = 8'($urandom_range(0, 255));
                1: msg_q.delete(at);
                default: msg_q.insert(at, t_raw_byte'{1'b0, 8'($urandom_range(0, 255))});
            endcase
        end
        msg_q[first].nm = ($urandom_range(0, 15) != 0);
    endfunction

    // Short run of loose bytes, biased toward protocol characters
    function automatic void build_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 4))
                0: b = CH_CR;
                1: b = CH_LF;
                2: b = CH_ZERO;
                3: b = hex_char($urandom_range(0, 15));
                default: b = 8'($urandom_range(0, 255));
            endcase
            put_byte($urandom_range(0, 5) == 0, b);
        end
    endfunction

    function automatic logic [CFG_W-1:0] limit_choice(input int unsigned k);
        case (k % 5)
            0: return MAX_BODY_RESET;
            1: return CFG_W'($urandom_range(0, 60));
            2: return 32'hffff_ffff;
            3: return 32'h0;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    // Offer one byte, wait for the handshake, then record what it should produce
    task automatic send_byte(input t_raw_byte item, input logic typed, input t_result want);
        int      gap;
        t_result predicted;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.new_message <= item.nm;
        in_ch.data_byte   <= item.b;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predicted = decode_byte(item.nm, item.b);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
        items_accepted++;
    endtask

    // Drop valid and drain every outstanding result
    task automatic pause_input();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] value);
        pause_input();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        body_limit = value;
    endtask

    // Result side: random stall bursts, plus one long hold-off on request
    initial begin
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
                run_left   = 0;
            end
            if (stall_left == 0 && run_left == 0) begin
                if (idle_on && $urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 17);
                else run_left = $urandom_range(1, 40);
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                run_left--;
            end
        end
    end

    // Compare each accepted result with the oldest pending one
    initial begin
        t_result want;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no request pending", int'(out_ch.status), 0);
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.body_byte !== want.body_byte)
                        report_mismatch("body_byte", int'(out_ch.body_byte), int'(want.body_byte));
                    if (out_ch.body_valid !== want.body_valid)
                        report_mismatch("body_valid", int'(out_ch.body_valid),
                                        int'(want.body_valid));
                    if (out_ch.status !== want.status)
                        report_mismatch("status", int'(out_ch.status), int'(want.status));
                    if (out_ch.error_kind !== want.error_kind)
                        report_mismatch("error_kind", int'(out_ch.error_kind),
                                        int'(want.error_kind));
                end
            end
        end
    end

    // Main sequence
    initial begin
        int unsigned next_limit_at;
        int unsigned pick;
        bit          hold_done;
        pick      = 0;
        hold_done = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        in_ch.valid       = 1'b0;
        in_ch.new_message = 1'b0;
        in_ch.data_byte   = 8'h00;
        body_limit        = MAX_BODY_RESET;
        clear_parse();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_LIMIT) begin
                write_limit(DIRECTED[i].limit);
            end else begin
                send_byte(t_raw_byte'{DIRECTED[i].nm, DIRECTED[i].b}, DIRECTED[i].typed,
                          DIRECTED[i].want);
            end
        end

        // Random messages and noise, with the limit changed between messages
        next_limit_at = items_accepted + LIMIT_EVERY;
        while (items_accepted < RUN_ITEMS) begin
            if (items_accepted >= next_limit_at) begin
                write_limit(limit_choice(pick));
                pick++;
                next_limit_at += LIMIT_EVERY;
            end
            if (!hold_done && items_accepted >= HOLD_AT) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (items_accepted >= RUN_ITEMS - QUIET_TAIL) idle_on = 1'b0;
            if ($urandom_range(0, 9) == 0) build_noise();
            else build_message();
            while (msg_q.size() != 0) send_byte(msg_q.pop_front(), 1'b0, UNCHECKED);
        end

        // Drain, then watch for any stray result before reporting
        pause_input();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
